### rtl/gtb_pkg.sv
package gtb_pkg;

  // Data widths
  localparam int XW  = 16;        // Q4.12 sample
  localparam int RW  = 30;        // exp argument r, Q31, always below 0.5
  localparam int PW  = 32;        // Q31 values in [0, 1.0]
  localparam int QF  = 31;        // Q31 fraction bits
  localparam int QW  = 32;        // quotient bits of the tanh divide
  localparam int QPW = PW + 1;    // 1 +/- tanh, up to 2.0 in Q31

  localparam int HORNER_STEPS = 12;
  localparam int SQUARINGS    = 5;

  localparam logic [PW-1:0] Q31_ONE  = 32'h8000_0000;
  localparam logic [19:0]   COEF_C24 = 20'd598568;    // 0.044715*sqrt(2/pi), Q24
  localparam logic [23:0]   COEF_B24 = 24'd13386282;  // sqrt(2/pi), Q24

  // floor(2^32 / j) for j = 1..12 (j = 1 uses 2^32 - 1); entry j-1
  localparam logic [PW-1:0] RECIP [HORNER_STEPS] = '{
    32'd4294967295, 32'd2147483648, 32'd1431655765, 32'd1073741824,
    32'd858993459,  32'd715827882,  32'd613566756,  32'd536870912,
    32'd477218588,  32'd429496729,  32'd390451572,  32'd357913941
  };

  // Side-band that rides along with each element
  typedef struct packed {
    logic [XW-1:0] m;     // |v|
    logic          neg;   // v < 0
    logic          sat;   // tanh argument >= 8
    logic          last;
  } gtb_side_t;

endpackage

### rtl/gtb_poly.sv
module gtb_poly (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic signed [gtb_pkg::XW-1:0] x,
  input  logic signed [gtb_pkg::XW-1:0] bias,
  input  logic                          last_in,
  output logic                          out_vld,
  output logic [gtb_pkg::RW-1:0]        r,
  output gtb_pkg::gtb_side_t            side
);
  import gtb_pkg::*;

  localparam int NST   = 5;
  localparam int V2W   = 2*XW - 1;    // |v|^2 <= 2^30
  localparam int TPW   = 20 + V2W;
  localparam int KW    = 26;          // C*v^2 + B in Q24
  localparam int AW    = XW + KW;
  localparam int SAT_B = 39;          // 8.0 in Q36
  localparam int R_SH  = 9;           // Q36 -> 2|u|/32 in Q31

  logic [NST-1:0]  vld;
  gtb_side_t       s0, s1, s2, s3;
  logic [XW:0]     sum;
  logic [XW-1:0]   v_sat;
  logic            neg_in;
  logic [XW-1:0]   m_in;
  logic [2*XW-1:0] v2_full;
  logic [V2W-1:0]  v2;
  logic [TPW-1:0]  t_prod;
  logic [KW-1:0]   t;
  logic [KW-1:0]   k;
  logic [AW-1:0]   a_full;

  // saturating add
  assign sum    = {x[XW-1], x} + {bias[XW-1], bias};
  assign v_sat  = (sum[XW] != sum[XW-1]) ?
                  (sum[XW] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}}) :
                  sum[XW-1:0];
  assign neg_in = v_sat[XW-1];
  assign m_in   = neg_in ? ({XW{1'b0}} - v_sat) : v_sat;

  assign v2_full = (2*XW)'(s0.m) * (2*XW)'(s0.m);
  assign t_prod  = TPW'(COEF_C24) * TPW'(v2);
  assign a_full  = AW'(s3.m) * AW'(k);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0   <= '{m: m_in, neg: neg_in, sat: 1'b0, last: last_in};
      s1   <= s0;
      v2   <= v2_full[V2W-1:0];
      s2   <= s1;
      t    <= t_prod[KW+23:24];
      s3   <= s2;
      k    <= t + KW'(COEF_B24);
      side <= '{m: s3.m, neg: s3.neg, sat: |a_full[AW-1:SAT_B], last: s3.last};
      r    <= a_full[R_SH+RW-1:R_SH];
    end
  end

  assign out_vld = vld[NST-1];

endmodule

### rtl/gtb_exp.sv
module gtb_exp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [gtb_pkg::RW-1:0] r,
  input  gtb_pkg::gtb_side_t     side_in,
  output logic                   out_vld,
  output logic [gtb_pkg::PW-1:0] e,
  output gtb_pkg::gtb_side_t     side_out
);
  import gtb_pkg::*;

  localparam int PRW = RW + PW;
  localparam int RMW = 5;     // remainder after reciprocal estimate stays below 24

  wire            h_vld  [HORNER_STEPS+1];
  wire [RW-1:0]   h_r    [HORNER_STEPS+1];
  wire [PW-1:0]   h_p    [HORNER_STEPS+1];
  wire gtb_side_t h_side [HORNER_STEPS+1];

  wire            q_vld  [SQUARINGS+1];
  wire [PW-1:0]   q_e    [SQUARINGS+1];
  wire gtb_side_t q_side [SQUARINGS+1];

  assign h_vld[0]  = in_vld;
  assign h_r[0]    = r;
  assign h_p[0]    = Q31_ONE;
  assign h_side[0] = side_in;

  // Horner on the Taylor series of exp(-r): p = 1 - (r*p)/j, j = 12 .. 1
  for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_horner
    localparam logic [3:0]    J = 4'(HORNER_STEPS - g);
    localparam logic [PW-1:0] M = RECIP[HORNER_STEPS - g - 1];

    logic           a_vld, b_vld, c_vld;
    logic [RW-1:0]  a_r, b_r, c_r;
    gtb_side_t      a_side, b_side, c_side;
    logic [RW-1:0]  a_s, b_s;
    logic [RW-1:0]  b_q0;
    logic [PW-1:0]  c_p;
    logic [PRW-1:0] prod_a;
    logic [PRW-1:0] prod_b;
    logic [RMW-1:0] rem;
    logic           inc;

    assign prod_a = PRW'(h_r[g]) * PRW'(h_p[g]);
    assign prod_b = PRW'(a_s) * PRW'(M);
    // estimate is floor(s/j) or one below; low bits settle which
    assign rem    = b_s[RMW-1:0] - RMW'(b_q0[RMW-1:0] * J);
    assign inc    = rem >= RMW'(J);

    always_ff @(posedge clk) begin
      if (rst) begin
        a_vld <= 1'b0;
        b_vld <= 1'b0;
        c_vld <= 1'b0;
      end else if (en) begin
        a_vld <= h_vld[g];
        b_vld <= a_vld;
        c_vld <= b_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r    <= h_r[g];
        a_side <= h_side[g];
        a_s    <= prod_a[QF+RW-1:QF];
        b_r    <= a_r;
        b_side <= a_side;
        b_s    <= a_s;
        b_q0   <= prod_b[PRW-1:PW];
        c_r    <= b_r;
        c_side <= b_side;
        c_p    <= Q31_ONE - PW'(b_q0) - PW'(inc);
      end
    end

    assign h_vld[g+1]  = c_vld;
    assign h_r[g+1]    = c_r;
    assign h_p[g+1]    = c_p;
    assign h_side[g+1] = c_side;
  end

  assign q_vld[0]  = h_vld[HORNER_STEPS];
  assign q_e[0]    = h_p[HORNER_STEPS];
  assign q_side[0] = h_side[HORNER_STEPS];

  // raise to the 32nd power: exp(-r)^32 = exp(-2|u|)
  for (genvar k = 0; k < SQUARINGS; k++) begin : g_square
    logic              vld;
    logic [PW-1:0]     sq;
    gtb_side_t         sd;
    logic [2*PW-1:0]   prod;

    assign prod = (2*PW)'(q_e[k]) * (2*PW)'(q_e[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= 1'b0;
      end else if (en) begin
        vld <= q_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq <= prod[QF+PW-1:QF];
        sd <= q_side[k];
      end
    end

    assign q_vld[k+1]  = vld;
    assign q_e[k+1]    = sq;
    assign q_side[k+1] = sd;
  end

  assign out_vld  = q_vld[SQUARINGS];
  assign e        = q_e[SQUARINGS];
  assign side_out = q_side[SQUARINGS];

  // series value of exp(-r) must land in [0.5, 1.0]
  a_horner_range: assert property (@(posedge clk) disable iff (rst)
    h_vld[HORNER_STEPS] |-> (h_p[HORNER_STEPS] >= (Q31_ONE >> 1)) &&
                            (h_p[HORNER_STEPS] <= Q31_ONE))
    else $error("exp series result out of range");

endmodule

### rtl/gtb_div.sv
module gtb_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [gtb_pkg::PW-1:0] e,
  input  gtb_pkg::gtb_side_t     side_in,
  output logic                   out_vld,
  output logic [gtb_pkg::QW-1:0] quo,
  output gtb_pkg::gtb_side_t     side_out
);
  import gtb_pkg::*;

  localparam int DW = PW + 1;   // divisor 1 + e, up to 2.0
  localparam int CW = DW + 1;   // shifted remainder

  // tanh = ((1 - e) << 31) / (1 + e), restoring, one quotient bit a stage
  wire            d_vld  [QW+1];
  wire [DW-1:0]   d_rem  [QW+1];
  wire [DW-1:0]   d_den  [QW+1];
  wire [QW-1:0]   d_quo  [QW+1];
  wire gtb_side_t d_side [QW+1];

  logic           p_vld;
  logic [DW-1:0]  p_rem;
  logic           p_lsb;
  logic [DW-1:0]  p_den;
  gtb_side_t      p_side;
  logic [PW-1:0]  numer;

  assign numer = Q31_ONE - e;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_rem  <= DW'(numer >> 1);
      p_lsb  <= numer[0];
      p_den  <= DW'(Q31_ONE) + DW'(e);
      p_side <= side_in;
    end
  end

  assign d_vld[0]  = p_vld;
  assign d_rem[0]  = p_rem;
  assign d_den[0]  = p_den;
  assign d_quo[0]  = '0;
  assign d_side[0] = p_side;

  for (genvar k = 0; k < QW; k++) begin : g_bit
    logic          vld;
    logic [DW-1:0] rem;
    logic [DW-1:0] den;
    logic [QW-1:0] qb;
    gtb_side_t     sd;
    logic          din;
    logic [CW-1:0] cand;
    logic [CW-1:0] diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign din = p_lsb;
    end else begin : g_rest
      assign din = 1'b0;
    end

    assign cand = {d_rem[k], din};
    assign diff = cand - CW'(d_den[k]);
    assign ge   = cand >= CW'(d_den[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= 1'b0;
      end else if (en) begin
        vld <= d_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem <= ge ? diff[DW-1:0] : cand[DW-1:0];
        den <= d_den[k];
        qb  <= {d_quo[k][QW-2:0], ge};
        sd  <= d_side[k];
      end
    end

    assign d_vld[k+1]  = vld;
    assign d_rem[k+1]  = rem;
    assign d_den[k+1]  = den;
    assign d_quo[k+1]  = qb;
    assign d_side[k+1] = sd;
  end

  assign out_vld  = d_vld[QW];
  assign quo      = d_quo[QW];
  assign side_out = d_side[QW];

  // (1 - e) / (1 + e) never exceeds one
  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    d_vld[QW] |-> (d_quo[QW] <= Q31_ONE))
    else $error("tanh quotient above one");

endmodule

### rtl/gelu_tanh_with_bias.sv
// Pipeline: a transaction passes 5 polynomial, 36 Horner, 5 squaring, 33 divide and 2 output-math
//   stages, then the output register.
// Throughput: one transaction per cycle while the skid entry is empty; every stage is a plain register slice.
// Reset (rst, synchronous): clears all valid bits and the output buffer; data regs keep junk.
// in_ready is a register: it drops only when both output buffer entries are full.
module gelu_tanh_with_bias (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [gtb_pkg::XW-1:0] x,
  input  logic signed [gtb_pkg::XW-1:0] bias,
  input  logic                          last_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [gtb_pkg::XW-1:0] y,
  output logic                          last_out
);
  import gtb_pkg::*;

  localparam int MPW = XW + QPW - 1;   // |v| * (1 +/- tanh) <= 2^47

  // Pipeline-wide advance. The whole datapath moves as one shift line;
  // it only halts while the skid entry is occupied.
  logic           en;

  logic           poly_vld;
  logic [RW-1:0]  poly_r;
  gtb_side_t      poly_side;

  logic           exp_vld;
  logic [PW-1:0]  exp_e;
  gtb_side_t      exp_side;

  logic           div_vld;
  logic [QW-1:0]  div_quo;
  gtb_side_t      div_side;

  logic [PW-1:0]  th;
  logic [QPW-1:0] q_next;
  logic           f1_vld;
  logic [QPW-1:0] f1_q;
  gtb_side_t      f1_side;

  logic [MPW-1:0] f2_prod_next;
  logic           f2_vld;
  logic [MPW-1:0] f2_prod;
  gtb_side_t      f2_side;

  logic [MPW-1:0] rounded;
  logic [XW-1:0]  mag;
  logic [XW-1:0]  y_next;

  logic           push;
  logic           pop;
  logic           skid_valid;
  logic [XW-1:0]  skid_y;
  logic           skid_last;

  assign en       = !skid_valid;
  assign in_ready = en;

  // v = sat(x + bias), |v|, then u = |v| * (C*v^2 + B) and the tanh argument
  gtb_poly u_poly (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_valid),
    .x       (x),
    .bias    (bias),
    .last_in (last_in),
    .out_vld (poly_vld),
    .r       (poly_r),
    .side    (poly_side)
  );

  // e = exp(-2|u|): 12-term Horner series then five squarings
  gtb_exp u_exp (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (poly_vld),
    .r        (poly_r),
    .side_in  (poly_side),
    .out_vld  (exp_vld),
    .e        (exp_e),
    .side_out (exp_side)
  );

  // tanh(|u|) = (1 - e) / (1 + e), bit-serial across 32 stages
  gtb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (exp_vld),
    .e        (exp_e),
    .side_in  (exp_side),
    .out_vld  (div_vld),
    .quo      (div_quo),
    .side_out (div_side)
  );

  // Large arguments (|u| >= 8) force tanh to exactly one. The sign of v
  // picks 1 + tanh or 1 - tanh since tanh is odd.
  assign th     = div_side.sat ? Q31_ONE : div_quo;
  assign q_next = div_side.neg ? (QPW'(Q31_ONE) - QPW'(th)) :
                                 (QPW'(Q31_ONE) + QPW'(th));

  assign f2_prod_next = MPW'(f1_side.m) * MPW'(f1_q);

  // 0.5 * |v| * q with round half up on the magnitude; |y| <= |v|
  assign rounded = f2_prod + MPW'(Q31_ONE);
  assign mag     = rounded[QF+XW:QF+1];
  assign y_next  = f2_side.neg ? ({XW{1'b0}} - mag) : mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
    end else if (en) begin
      f1_vld <= div_vld;
      f2_vld <= f1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_q    <= q_next;
      f1_side <= div_side;
      f2_prod <= f2_prod_next;
      f2_side <= f1_side;
    end
  end

  // Two-entry output buffer: head drives the ports, skid catches the one
  // transaction still in flight when the consumer stalls.
  assign push = en && f2_vld;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push) begin
        if (!out_valid || pop) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && (!out_valid || pop)) begin
      y        <= y_next;
      last_out <= f2_side.last;
    end else if (push) begin
      skid_y    <= y_next;
      skid_last <= f2_side.last;
    end else if (pop && skid_valid) begin
      y        <= skid_y;
      last_out <= skid_last;
    end
  end

  // skid is only used behind an occupied head
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty head");

  // skid fills only when the head was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid filled without output stall");

endmodule

### dv/gelu_tanh_with_bias_tb.sv
`timescale 1ns / 100ps

module gelu_tanh_with_bias_tb;

  localparam int W           = gtb_pkg::XW;
  localparam int CYCLE_LIMIT = 200000;   // watchdog limit for the whole run
  localparam int TAIL_CYCLES = 100;      // idle tail after the final drain

  // Predictor constants, Q24 / Q31 / Q36
  localparam longint unsigned CUBIC_Q24  = 64'd598568;     // 0.044715 * sqrt(2/pi)
  localparam longint unsigned LINEAR_Q24 = 64'd13386282;   // sqrt(2/pi)
  localparam longint unsigned ONE_Q31    = 64'h8000_0000;
  localparam longint unsigned TANH_CLIP  = 64'd1 << 39;    // |u| >= 8 in Q36

  typedef struct {
    logic signed [W-1:0] y;
    logic                last;
  } gelu_out_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic signed [W-1:0] x;
  logic signed [W-1:0] bias;
  logic                last_in;
  logic                out_valid;
  logic                out_ready;
  logic signed [W-1:0] y;
  logic                last_out;

  gelu_out_t pending_gelu[$];   // predicted results, oldest first
  gelu_out_t want;

  int errors       = 0;
  int accepted     = 0;
  int checked      = 0;
  int stall_cycles = 0;   // cycles the block held off a waiting input transaction
  int cycles       = 0;

  // Idle percentages, set per phase by the main sequence and the test tasks
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;  // receiver forced hold-off, counted down by the receiver

  gelu_tanh_with_bias u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .x         (x),
    .bias      (bias),
    .last_in   (last_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .y         (y),
    .last_out  (last_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Predictor: tanh GELU in integer arithmetic, all magnitudes 64-bit
  // ------------------------------------------------------------------

  // tanh of a nonnegative Q36 argument, Q31 result.
  // exp(-2|u|) = exp(-2|u|/32)^32: Taylor/Horner on the small argument,
  // then five squarings.
  function automatic longint unsigned tanh_mag_q31(input longint unsigned arg);
    longint unsigned r;
    longint unsigned p;
    longint unsigned e;
    if (arg >= TANH_CLIP)
      return ONE_Q31;
    r = arg >> 9;
    p = ONE_Q31;
    for (int j = 12; j >= 1; j--)
      p = ONE_Q31 - ((r * p) >> 31) / longint'(j);
    e = p;
    repeat (5) e = (e * e) >> 31;
    return ((ONE_Q31 - e) << 31) / (ONE_Q31 + e);
  endfunction

  function automatic logic signed [W-1:0] gelu_q412(input logic signed [W-1:0] xv,
                                                    input logic signed [W-1:0] bv);
    int              sum;
    logic            neg;
    longint unsigned mag;
    longint unsigned poly;
    longint unsigned th;
    longint unsigned q;
    longint unsigned res;
    sum = int'(xv) + int'(bv);
    if (sum > 32767)
      sum = 32767;
    else if (sum < -32768)
      sum = -32768;
    neg  = (sum < 0);
    mag  = neg ? longint'(-sum) : longint'(sum);
    poly = ((CUBIC_Q24 * mag * mag) >> 24) + LINEAR_Q24;  // C*v^2 + B, Q24
    th   = tanh_mag_q31(mag * poly);
    q    = neg ? (ONE_Q31 - th) : (ONE_Q31 + th);
    res  = (mag * q + ONE_Q31) >> 32;                     // round half up on |y|
    return neg ? -W'(res) : W'(res);
  endfunction

  // ------------------------------------------------------------------
  // Input side
  // ------------------------------------------------------------------

  // Offer one transaction; returns at the edge that accepts it. in_valid is
  // left high so back-to-back transactions never toggle it within one step.
  task automatic send_elem(input logic signed [W-1:0] xv, input logic signed [W-1:0] bv,
                           input logic lv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x        <= xv;
    bias     <= bv;
    last_in  <= lv;
    @(posedge clk);
    while (!in_ready) begin
      stall_cycles++;
      @(posedge clk);
    end
    pending_gelu.push_back('{y: gelu_q412(xv, bv), last: lv});
    accepted++;
  endtask

  // Stop offering and wait for every predicted result to come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_gelu.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic signed [W-1:0] rand_sample();
    case ($urandom_range(0, 3))
      0, 1:    return W'($urandom);                                 // whole range
      2:       return W'(int'($urandom_range(0, 48000)) - 24000);   // knee and clip region
      default: return W'(int'($urandom_range(0, 1024)) - 512);      // near zero
    endcase
  endfunction

  function automatic logic signed [W-1:0] rand_bias();
    // a quarter of the elements behave as if no bias tensor were present
    return ($urandom_range(0, 3) == 0) ? '0 : rand_sample();
  endfunction

  // ------------------------------------------------------------------
  // Output side
  // ------------------------------------------------------------------

  // Receiver: random stalls, or a forced hold-off while hold_left runs down
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Result checker: every accepted output transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst) begin
      if ($isunknown(out_valid)) begin
        $error("out_valid unknown after reset");
        errors++;
      end else if (out_valid && out_ready) begin
        if (pending_gelu.size() == 0) begin
          $error("unexpected result: y=%0d last_out=%0b", y, last_out);
          errors++;
        end else begin
          want = pending_gelu.pop_front();
          checked++;
          if (y !== want.y) begin
            $error("y mismatch: expected %0d, got %0d", want.y, y);
            errors++;
          end
          if (last_out !== want.last) begin
            $error("last_out mismatch: expected %0b, got %0b", want.last, last_out);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             pending_gelu.size());
    $display("gelu_tanh_with_bias_tb failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Field extremes, sum saturation, sign handling and the tanh clip boundary
  task automatic test_directed();
    send_elem(16'h0000, 16'h0000, 1'b0);   // zero
    send_elem(16'h7FFF, 16'h0000, 1'b0);   // max positive, tanh clipped
    send_elem(16'h8000, 16'h0000, 1'b1);   // max negative, result rounds to zero
    send_elem(16'h7FFF, 16'h7FFF, 1'b0);   // sum saturates high
    send_elem(16'h8000, 16'h8000, 1'b0);   // sum saturates low
    send_elem(16'h7FFF, 16'h0001, 1'b1);   // just past the top
    send_elem(16'h8000, 16'hFFFF, 1'b0);   // just past the bottom
    send_elem(16'h0001, 16'h0000, 1'b0);   // one LSB
    send_elem(16'hFFFF, 16'h0000, 1'b0);   // minus one LSB
    send_elem(16'h0000, 16'h1000, 1'b0);   // bias alone, +1.0
    send_elem(16'h1000, 16'hF000, 1'b1);   // x and bias cancel
    send_elem(16'h1000, 16'h0000, 1'b0);   // +1.0
    send_elem(16'hF000, 16'h0000, 1'b0);   // -1.0
    send_elem(16'sd19900, 16'h0000, 1'b0); // either side of |u| = 8
    send_elem(16'sd20000, 16'h0000, 1'b0);
    send_elem(-16'sd19900, 16'h0000, 1'b0);
    send_elem(-16'sd20000, 16'h0000, 1'b1);
    send_elem(16'h5555, 16'hAAAA, 1'b1);   // alternating bit patterns
    send_elem(16'hAAAA, 16'h5555, 1'b0);
    send_elem(16'h3000, -16'sd20000, 1'b1);// mixed signs, negative sum
    send_elem(-16'sd6000, 16'h0800, 1'b0); // negative knee region
    drain();
  endtask

  task automatic test_random_stream(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n)
      send_elem(rand_sample(), rand_bias(), ($urandom_range(0, 15) == 0));
    // sender pauses here until every outstanding result has come back
    drain();
  endtask

  // Receiver holds off long enough for the pipeline and output buffer to fill,
  // while the sender keeps offering, so in_ready has to drop
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 300;
    repeat (150)
      send_elem(rand_sample(), rand_bias(), ($urandom_range(0, 15) == 0));
    drain();
  endtask

  initial begin
    int directed;
    rst      = 1'b1;
    in_valid = 1'b0;
    x        = '0;
    bias     = '0;
    last_in  = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 69;
    test_directed();
    directed = accepted;

    test_random_stream(150, 30, 69);
    test_random_stream(150, 69, 30);
    test_random_stream(150, 0, 0);
    test_output_stall();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d transactions (%0d directed), %0d results checked",
             accepted, directed, checked);
    $display("input stalled %0d cycles under output back-pressure", stall_cycles);
    if (errors == 0 && pending_gelu.size() == 0) begin
      $display("gelu_tanh_with_bias_tb passed");
    end else begin
      $display("gelu_tanh_with_bias_tb failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/gtb_pkg.sv
rtl/gtb_poly.sv
rtl/gtb_exp.sv
rtl/gtb_div.sv
rtl/gelu_tanh_with_bias.sv
dv/gelu_tanh_with_bias_tb.sv
